[design/bpnm_pkg.sv]
// bpnm_pkg: shared types, constants and helpers for the binary pnm reader
// no dependencies; imported by the interfaces, the divider and the top level
`timescale 1ns / 1ps

package bpnm_pkg;

    // width of the parsed dimension and maxval stores
    localparam int DIM_BITS   = 16;
    localparam int FIELD_W    = 16;
    localparam int SAMPLE_W   = 8;
    localparam int COUNT_W    = 2 * DIM_BITS + 2;
    localparam int DIV_STEPS  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int DIVIDEND_W = 2 * SAMPLE_W;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_BAD_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_MAXVAL_HIGH = 2'd1;
    localparam logic [1:0] ERR_MAXVAL_ZERO = 2'd2;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd3;

    // characters of the file syntax
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] CH_FIVE    = 8'h35;
    localparam logic [7:0] CH_SIX     = 8'h36;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_file;
    } bpnm_in_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] sample;
        logic [FIELD_W-1:0]  image_width;
        logic [FIELD_W-1:0]  image_height;
        logic [FIELD_W-1:0]  max_sample;
        logic [1:0]          channel_count;
        logic [1:0]          error_code;
        logic                last;
    } bpnm_out_t;

    // divider request and status
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [SAMPLE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } div_stat_t;

    // saturate a stored dimension to the 16-bit result field
    function automatic logic [FIELD_W-1:0] sat_field(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS+FIELD_W-1:0] ext;
        logic [DIM_BITS+FIELD_W-1:0] lim;
        ext = {{FIELD_W{1'b0}}, v};
        lim = {{DIM_BITS{1'b0}}, {FIELD_W{1'b1}}};
        if (ext > lim)
        begin
            return {FIELD_W{1'b1}};
        end
        return ext[FIELD_W-1:0];
    endfunction

endpackage

[design/bpnm_ifs.sv]
// bpnm_ifs: valid/ready channel interfaces for the byte stream and the results
// depends on bpnm_pkg for the payload structs
`timescale 1ns / 1ps

interface bpnm_byte_if;
    import bpnm_pkg::*;
    logic     valid;
    logic     ready;
    bpnm_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpnm_result_if;
    import bpnm_pkg::*;
    logic      valid;
    logic      ready;
    bpnm_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/binary_pnm_header_and_sample_scaler.sv]
// binary_pnm_header_and_sample_scaler: binary pnm (P5/P6) header parser and sample scaler
// depends on bpnm_pkg, bpnm_ifs and bpnm_div
//
//  channel        | dir | payload                                   | transaction
//  ---------------+-----+-------------------------------------------+------------------------
//  byte_stream    | in  | data_byte, start_file                     | one file byte
//  result_stream  | out | kind, sample, image_width/height,         | at most one per byte
//                 |     | max_sample, channel_count, error_code, last |
//
// a header byte is accepted and then parsed in a step; the byte ending maxval then goes on
// through the width*height multiply, the channel scale and the header report
// a raster byte is accepted, stepped and sent; when maxval is below 255 the divider runs its
// 8 quotient steps in between unless the scaled value saturates at once, and when maxval
// is 255 the byte passes straight through
// rst_n clears the parser to "awaiting magic letter" with all stores at their reset values
// a stalled result_stream holds finished results in the output register; the block only
// waits where a new result must be loaded into it
`timescale 1ns / 1ps

module binary_pnm_header_and_sample_scaler (
    input  logic                 clk,
    input  logic                 rst_n,
    bpnm_byte_if.sink            byte_stream,
    bpnm_result_if.source        result_stream
);
    import bpnm_pkg::*;

    // parser phases
    localparam logic [3:0] PH_MAGIC_P   = 4'd0;
    localparam logic [3:0] PH_MAGIC_NUM = 4'd1;
    localparam logic [3:0] PH_MAGIC_BAD = 4'd2;
    localparam logic [3:0] PH_W_SKIP    = 4'd3;
    localparam logic [3:0] PH_W_DIG     = 4'd4;
    localparam logic [3:0] PH_H_SKIP    = 4'd5;
    localparam logic [3:0] PH_H_DIG     = 4'd6;
    localparam logic [3:0] PH_M_SKIP    = 4'd7;
    localparam logic [3:0] PH_M_DIG     = 4'd8;
    localparam logic [3:0] PH_RASTER    = 4'd9;
    localparam logic [3:0] PH_IDLE      = 4'd10;

    // sequencer states
    localparam logic [2:0] ST_WAIT = 3'd0;  // ready for a byte
    localparam logic [2:0] ST_STEP = 3'd1;  // parse the latched byte
    localparam logic [2:0] ST_DIV  = 3'd2;  // divider scaling a sample
    localparam logic [2:0] ST_MUL  = 3'd3;  // width * height
    localparam logic [2:0] ST_CH   = 3'd4;  // times channel count
    localparam logic [2:0] ST_HDR  = 3'd5;  // header report

    localparam logic [DIM_BITS-1:0] NUM_CAP = {DIM_BITS{1'b1}};
    localparam logic [DIM_BITS-1:0] V255    = DIM_BITS'(255);

    logic [2:0]            state_reg, state_next;
    logic [3:0]            phase_reg, phase_next;
    logic                  comment_reg, comment_next;
    logic [DIM_BITS-1:0]   acc_reg, acc_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [DIM_BITS-1:0]   maxval_reg, maxval_next;
    logic [1:0]            chan_reg, chan_next;
    logic [COUNT_W-1:0]    left_reg, left_next;
    logic [2*DIM_BITS-1:0] prod_reg, prod_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  start_reg, start_next;
    logic                  out_valid_reg, out_valid_next;
    bpnm_out_t             out_reg, out_next;

    // parse state as seen by the byte, after a start_file reset
    logic [3:0]            ph_eff;
    logic                  cm_eff;
    logic [DIM_BITS-1:0]   acc_eff;
    logic [DIM_BITS-1:0]   wd_eff;
    logic [DIM_BITS-1:0]   ht_eff;
    logic [DIM_BITS-1:0]   mx_eff;
    logic [1:0]            ch_eff;
    logic [COUNT_W-1:0]    left_eff;

    logic                  is_digit;
    logic [DIM_BITS-1:0]   digit_val;
    logic [DIM_BITS+3:0]   acc_wide;
    logic [DIVIDEND_W-1:0] dividend;
    logic                  out_free;

    div_req_t              div_req;
    div_stat_t             div_stat;

    bpnm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    assign out_free = !out_valid_reg || result_stream.ready;

    always_comb
    begin
        if (start_reg)
        begin
            ph_eff   = PH_MAGIC_P;
            cm_eff   = 1'b0;
            acc_eff  = '0;
            wd_eff   = '0;
            ht_eff   = '0;
            mx_eff   = '0;
            ch_eff   = 2'd1;
            left_eff = '0;
        end
        else
        begin
            ph_eff   = phase_reg;
            cm_eff   = comment_reg;
            acc_eff  = acc_reg;
            wd_eff   = width_reg;
            ht_eff   = height_reg;
            mx_eff   = maxval_reg;
            ch_eff   = chan_reg;
            left_eff = left_reg;
        end
    end

    assign is_digit  = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign digit_val = DIM_BITS'(byte_reg - CH_ZERO);
    // acc * 10 + digit, four guard bits
    assign acc_wide  = ({4'b0, acc_eff} << 3) + ({4'b0, acc_eff} << 1)
                     + {4'b0, digit_val};
    // sample * 255
    assign dividend  = {byte_reg, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, byte_reg};

    always_comb
    begin
        logic [3:0]          t_ph;
        logic                t_cm;
        logic [DIM_BITS-1:0] t_acc;
        logic [DIM_BITS-1:0] t_wd;
        logic [DIM_BITS-1:0] t_ht;
        logic [DIM_BITS-1:0] t_mx;
        logic [1:0]          t_ch;
        logic [COUNT_W-1:0]  t_left;
        logic                fin;
        logic [DIM_BITS-1:0] fin_v;
        logic                res;
        logic [1:0]          res_kind;
        logic [SAMPLE_W-1:0] res_sample;
        logic [1:0]          res_err;
        logic                res_last;
        logic                go_div;
        logic                go_mul;
        logic                load;

        state_next     = state_reg;
        phase_next     = phase_reg;
        comment_next   = comment_reg;
        acc_next       = acc_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        maxval_next    = maxval_reg;
        chan_next      = chan_reg;
        left_next      = left_reg;
        prod_next      = prod_reg;
        byte_next      = byte_reg;
        start_next     = start_reg;
        div_req.start    = 1'b0;
        div_req.dividend = dividend;
        div_req.divisor  = maxval_reg[SAMPLE_W-1:0];

        t_ph       = ph_eff;
        t_cm       = cm_eff;
        t_acc      = acc_eff;
        t_wd       = wd_eff;
        t_ht       = ht_eff;
        t_mx       = mx_eff;
        t_ch       = ch_eff;
        t_left     = left_eff;
        fin        = 1'b0;
        fin_v      = '0;
        res        = 1'b0;
        res_kind   = KIND_HEADER;
        res_sample = '0;
        res_err    = ERR_BAD_MAGIC;
        res_last   = 1'b0;
        go_div     = 1'b0;
        go_mul     = 1'b0;
        load       = 1'b0;

        unique case (state_reg)
            ST_WAIT:
            begin
                if (byte_stream.valid)
                begin
                    byte_next  = byte_stream.data.data_byte;
                    start_next = byte_stream.data.start_file;
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                unique case (ph_eff)
                    PH_MAGIC_P:
                    begin
                        t_ph = (byte_reg == CH_P) ? PH_MAGIC_NUM : PH_MAGIC_BAD;
                    end
                    PH_MAGIC_BAD:
                    begin
                        t_ph     = PH_IDLE;
                        res      = 1'b1;
                        res_kind = KIND_ERROR;
                        res_err  = ERR_BAD_MAGIC;
                    end
                    PH_MAGIC_NUM:
                    begin
                        if (byte_reg < CH_ONE || byte_reg > CH_SIX)
                        begin
                            t_ph     = PH_IDLE;
                            res      = 1'b1;
                            res_kind = KIND_ERROR;
                            res_err  = ERR_BAD_MAGIC;
                        end
                        else if (byte_reg <= CH_FOUR)
                        begin
                            // ascii and bitmap formats are not handled
                            t_ph     = PH_IDLE;
                            res      = 1'b1;
                            res_kind = KIND_ERROR;
                            res_err  = ERR_UNSUPPORTED;
                        end
                        else
                        begin
                            t_ch  = (byte_reg == CH_FIVE) ? 2'd1 : 2'd3;
                            t_ph  = PH_W_SKIP;
                            t_cm  = 1'b0;
                            t_acc = '0;
                        end
                    end
                    PH_W_SKIP, PH_H_SKIP, PH_M_SKIP:
                    begin
                        if (byte_reg == CH_NUL)
                        begin
                            // nul ends the number as zero
                            fin   = 1'b1;
                            fin_v = '0;
                        end
                        else if (cm_eff)
                        begin
                            if (byte_reg == CH_NEWLINE)
                            begin
                                t_cm = 1'b0;
                            end
                        end
                        else if (byte_reg == CH_HASH)
                        begin
                            t_cm = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            t_acc = digit_val;
                            t_ph  = ph_eff + 4'd1;
                        end
                    end
                    PH_W_DIG, PH_H_DIG, PH_M_DIG:
                    begin
                        if (is_digit)
                        begin
                            t_acc = (acc_wide > {4'b0, NUM_CAP}) ? NUM_CAP
                                                                 : acc_wide[DIM_BITS-1:0];
                        end
                        else
                        begin
                            fin   = 1'b1;
                            fin_v = acc_eff;
                        end
                    end
                    PH_RASTER:
                    begin
                        if (left_eff != '0)
                        begin
                            t_left = left_eff - COUNT_W'(1);
                        end
                        if (t_left == '0)
                        begin
                            t_ph = PH_IDLE;
                        end
                        if (mx_eff == V255)
                        begin
                            // full-scale maxval passes the byte through
                            res        = 1'b1;
                            res_kind   = KIND_SAMPLE;
                            res_sample = byte_reg;
                            res_last   = (t_left == '0);
                        end
                        else
                        begin
                            go_div = 1'b1;
                        end
                    end
                    default:
                    begin
                        t_ph = ph_eff;
                    end
                endcase

                if (fin)
                begin
                    t_acc = '0;
                    t_cm  = 1'b0;
                    if (ph_eff == PH_W_SKIP || ph_eff == PH_W_DIG)
                    begin
                        t_wd = fin_v;
                        t_ph = PH_H_SKIP;
                    end
                    else if (ph_eff == PH_H_SKIP || ph_eff == PH_H_DIG)
                    begin
                        t_ht = fin_v;
                        t_ph = PH_M_SKIP;
                    end
                    else
                    begin
                        t_mx = fin_v;
                        if (fin_v > V255)
                        begin
                            t_ph     = PH_IDLE;
                            res      = 1'b1;
                            res_kind = KIND_ERROR;
                            res_err  = ERR_MAXVAL_HIGH;
                        end
                        else if (fin_v == '0)
                        begin
                            t_ph     = PH_IDLE;
                            res      = 1'b1;
                            res_kind = KIND_ERROR;
                            res_err  = ERR_MAXVAL_ZERO;
                        end
                        else
                        begin
                            go_mul = 1'b1;
                        end
                    end
                end

                // a step that yields a result waits for room in the output register
                if (!res || out_free)
                begin
                    phase_next   = t_ph;
                    comment_next = t_cm;
                    acc_next     = t_acc;
                    width_next   = t_wd;
                    height_next  = t_ht;
                    maxval_next  = t_mx;
                    chan_next    = t_ch;
                    left_next    = t_left;
                    load         = res;
                    div_req.start = go_div;
                    if (go_div)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (go_mul)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_stat.done && out_free)
                begin
                    res        = 1'b1;
                    res_kind   = KIND_SAMPLE;
                    res_sample = div_stat.quotient;
                    res_last   = (left_reg == '0);
                    load       = 1'b1;
                    state_next = ST_WAIT;
                end
            end

            ST_MUL:
            begin
                prod_next  = width_reg * height_reg;
                state_next = ST_CH;
            end

            ST_CH:
            begin
                left_next = (chan_reg == 2'd3)
                          ? ({2'b0, prod_reg} + {1'b0, prod_reg, 1'b0})
                          : {2'b0, prod_reg};
                state_next = ST_HDR;
            end

            ST_HDR:
            begin
                if (out_free)
                begin
                    res        = 1'b1;
                    res_kind   = KIND_HEADER;
                    res_last   = (left_reg == '0);
                    load       = 1'b1;
                    phase_next = (left_reg == '0) ? PH_IDLE : PH_RASTER;
                    state_next = ST_WAIT;
                end
            end

            default:
            begin
                state_next = ST_WAIT;
            end
        endcase

        // output register
        out_next = out_reg;
        if (load)
        begin
            out_next.kind          = res_kind;
            out_next.sample        = res_sample;
            out_next.image_width   = sat_field(width_next);
            out_next.image_height  = sat_field(height_next);
            out_next.max_sample    = sat_field(maxval_next);
            out_next.channel_count = chan_next;
            out_next.error_code    = (res_kind == KIND_ERROR) ? res_err : ERR_BAD_MAGIC;
            out_next.last          = res_last;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            phase_reg     <= PH_MAGIC_P;
            comment_reg   <= 1'b0;
            acc_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            maxval_reg    <= '0;
            chan_reg      <= 2'd1;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            comment_reg   <= comment_next;
            acc_reg       <= acc_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            maxval_reg    <= maxval_next;
            chan_reg      <= chan_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        byte_reg  <= byte_next;
        start_reg <= start_next;
        out_reg   <= out_next;
    end

    assign byte_stream.ready   = (state_reg == ST_WAIT);
    assign result_stream.valid = out_valid_reg;
    assign result_stream.data  = out_reg;

endmodule

[design/bpnm_div.sv]
// bpnm_div: restoring divider, one quotient bit per cycle while busy, saturating at 255
// depends on bpnm_pkg for the request and status structs
`timescale 1ns / 1ps

module bpnm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bpnm_pkg::div_req_t  req,
    output bpnm_pkg::div_stat_t stat
);
    import bpnm_pkg::*;

    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [SAMPLE_W-1:0]  low_reg, low_next;
    logic [SAMPLE_W-1:0]  quo_reg, quo_next;
    logic [SAMPLE_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SAMPLE_W:0]    part;
    logic [SAMPLE_W:0]    diff;

    assign part = {rem_reg, low_reg[SAMPLE_W-1]};
    assign diff = part - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start)
        begin
            dvs_next = req.divisor;
            // quotient would need more than eight bits: saturate
            if (req.dividend[DIVIDEND_W-1:SAMPLE_W] >= req.divisor)
            begin
                quo_next  = SAMPLE_MAX;
                cnt_next  = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = req.dividend[DIVIDEND_W-1:SAMPLE_W];
                low_next  = req.dividend[SAMPLE_W-1:0];
                quo_next  = '0;
                cnt_next  = DIV_CNT_W'(DIV_STEPS);
                busy_next = 1'b1;
                done_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (part >= {1'b0, dvs_reg})
            begin
                rem_next = diff[SAMPLE_W-1:0];
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = part[SAMPLE_W-1:0];
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b0};
            end
            low_next = {low_reg[SAMPLE_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

[test/testbench.sv]
// testbench: self-checking bench for the binary pnm header parser and sample scaler
// depends on bpnm_pkg, bpnm_ifs and binary_pnm_header_and_sample_scaler
// byte files go in with random gaps and stalls, each report is checked against a predictor
`timescale 1ns / 1ps

module testbench;
    import bpnm_pkg::*;

    // codes and characters the bench needs beyond the package
    localparam logic [1:0]  ERR_NONE       = 2'd0;
    localparam logic [1:0]  GRAY_CHANNELS  = 2'd1;
    localparam logic [1:0]  COLOR_CHANNELS = 2'd3;
    localparam logic [7:0]  CH_SPACE       = 8'h20;
    localparam logic [7:0]  CH_TAB         = 8'h09;
    localparam logic [7:0]  CH_RETURN      = 8'h0D;
    localparam logic [7:0]  CH_LETTER_X    = 8'h58;
    localparam int unsigned MAX_LEVEL      = 255;
    localparam int unsigned DIM_CAP        = 65535;

    // parser position, mirrors the block's phases
    typedef enum logic [3:0] {
        SCAN_MAGIC_LETTER,
        SCAN_MAGIC_DIGIT,
        SCAN_MAGIC_BAD,
        SCAN_W_SKIP,
        SCAN_W_DIGITS,
        SCAN_H_SKIP,
        SCAN_H_DIGITS,
        SCAN_M_SKIP,
        SCAN_M_DIGITS,
        SCAN_RASTER,
        SCAN_DONE
    } scan_phase_t;

    logic clk;
    logic rst_n;

    bpnm_byte_if   byte_ch();
    bpnm_result_if result_ch();

    binary_pnm_header_and_sample_scaler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_ch),
        .result_stream (result_ch)
    );

    // predictor state
    scan_phase_t scan_phase;
    bit          in_comment_q;
    logic [15:0] number_q;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [15:0] maxval_q;
    logic [1:0]  channels_q;
    logic [33:0] samples_due;

    // reports predicted but not yet seen on the result channel
    bpnm_out_t pnm_reports_due[$];
    bpnm_out_t report_want;

    int failures;
    int parsed_bytes;
    int report_count;
    int sender_idle_pct;
    int receiver_idle_pct;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic bit is_dec_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic void restart_parse();
        scan_phase   = SCAN_MAGIC_LETTER;
        in_comment_q = 1'b0;
        number_q     = '0;
        width_q      = '0;
        height_q     = '0;
        maxval_q     = '0;
        channels_q   = GRAY_CHANNELS;
        samples_due  = '0;
    endfunction

    // every report carries the stores as they stand
    function automatic void queue_report(input logic [1:0] kind, input logic [7:0] level,
                                         input logic [1:0] err, input logic fin);
        bpnm_out_t r;
        r.kind          = kind;
        r.sample        = level;
        r.image_width   = width_q;
        r.image_height  = height_q;
        r.max_sample    = maxval_q;
        r.channel_count = channels_q;
        r.error_code    = err;
        r.last          = fin;
        pnm_reports_due.push_back(r);
    endfunction

    // a number has ended: store it and move on, maxval also decides the header
    function automatic void close_number(input logic [15:0] v);
        number_q     = '0;
        in_comment_q = 1'b0;
        case (scan_phase)
            SCAN_W_SKIP, SCAN_W_DIGITS:
            begin
                width_q    = v;
                scan_phase = SCAN_H_SKIP;
            end
            SCAN_H_SKIP, SCAN_H_DIGITS:
            begin
                height_q   = v;
                scan_phase = SCAN_M_SKIP;
            end
            default:
            begin
                maxval_q = v;
                if (v > MAX_LEVEL)
                begin
                    // over 255 is checked before zero
                    scan_phase = SCAN_DONE;
                    queue_report(KIND_ERROR, '0, ERR_MAXVAL_HIGH, 1'b0);
                end
                else if (v == '0)
                begin
                    scan_phase = SCAN_DONE;
                    queue_report(KIND_ERROR, '0, ERR_MAXVAL_ZERO, 1'b0);
                end
                else
                begin
                    samples_due = 34'(width_q) * 34'(height_q) * 34'(channels_q);
                    if (samples_due == '0)
                    begin
                        // empty image: header closes the file
                        scan_phase = SCAN_DONE;
                        queue_report(KIND_HEADER, '0, ERR_NONE, 1'b1);
                    end
                    else
                    begin
                        scan_phase = SCAN_RASTER;
                        queue_report(KIND_HEADER, '0, ERR_NONE, 1'b0);
                    end
                end
            end
        endcase
    endfunction

    // takes one accepted byte, returns 1 when the block ignores it
    function automatic bit parse_and_scale(input logic [7:0] b, input logic new_file);
        int unsigned grown;
        int unsigned scaled;
        bit          ignored;
        if (new_file)
        begin
            restart_parse();
        end
        ignored = (scan_phase == SCAN_DONE);
        case (scan_phase)
            SCAN_MAGIC_LETTER:
            begin
                scan_phase = (b == CH_P) ? SCAN_MAGIC_DIGIT : SCAN_MAGIC_BAD;
            end
            SCAN_MAGIC_BAD:
            begin
                // bad letter is reported only once the second byte is in
                scan_phase = SCAN_DONE;
                queue_report(KIND_ERROR, '0, ERR_BAD_MAGIC, 1'b0);
            end
            SCAN_MAGIC_DIGIT:
            begin
                if (b < CH_ONE || b > CH_SIX)
                begin
                    scan_phase = SCAN_DONE;
                    queue_report(KIND_ERROR, '0, ERR_BAD_MAGIC, 1'b0);
                end
                else if (b <= CH_FOUR)
                begin
                    scan_phase = SCAN_DONE;
                    queue_report(KIND_ERROR, '0, ERR_UNSUPPORTED, 1'b0);
                end
                else
                begin
                    channels_q   = (b == CH_FIVE) ? GRAY_CHANNELS : COLOR_CHANNELS;
                    scan_phase   = SCAN_W_SKIP;
                    in_comment_q = 1'b0;
                    number_q     = '0;
                end
            end
            SCAN_W_SKIP, SCAN_H_SKIP, SCAN_M_SKIP:
            begin
                if (b == CH_NUL)
                begin
                    close_number('0);
                end
                else if (in_comment_q)
                begin
                    if (b == CH_NEWLINE)
                    begin
                        in_comment_q = 1'b0;
                    end
                end
                else if (b == CH_HASH)
                begin
                    in_comment_q = 1'b1;
                end
                else if (is_dec_digit(b))
                begin
                    number_q = 16'(b - CH_ZERO);
                    case (scan_phase)
                        SCAN_W_SKIP: scan_phase = SCAN_W_DIGITS;
                        SCAN_H_SKIP: scan_phase = SCAN_H_DIGITS;
                        default:     scan_phase = SCAN_M_DIGITS;
                    endcase
                end
            end
            SCAN_W_DIGITS, SCAN_H_DIGITS, SCAN_M_DIGITS:
            begin
                if (is_dec_digit(b))
                begin
                    grown    = number_q * 10 + (b - CH_ZERO);
                    number_q = (grown > DIM_CAP) ? 16'(DIM_CAP) : 16'(grown);
                end
                else
                begin
                    // the terminator is consumed
                    close_number(number_q);
                end
            end
            SCAN_RASTER:
            begin
                scaled = b;
                if (maxval_q < MAX_LEVEL && maxval_q != '0)
                begin
                    scaled = (b * MAX_LEVEL) / maxval_q;
                    if (scaled > MAX_LEVEL)
                    begin
                        scaled = MAX_LEVEL;
                    end
                end
                if (samples_due != '0)
                begin
                    samples_due = samples_due - 1'b1;
                end
                if (samples_due == '0)
                begin
                    scan_phase = SCAN_DONE;
                end
                queue_report(KIND_SAMPLE, 8'(scaled), ERR_NONE, samples_due == '0);
            end
            default:
            begin
            end
        endcase
        return ignored;
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: report %0d %s mismatch, expected %0h, actual %0h",
                     $time, report_count, name, want, got);
            failures++;
        end
    endfunction

    // every accepted report is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pnm_reports_due.size() == 0)
            begin
                $display("%0t ns: report %0d unexpected, expected none, actual %h",
                         $time, report_count, result_ch.data);
                failures++;
            end
            else
            begin
                report_want = pnm_reports_due.pop_front();
                check_field("kind", report_want.kind, result_ch.data.kind);
                check_field("sample", report_want.sample, result_ch.data.sample);
                check_field("image_width", report_want.image_width,
                            result_ch.data.image_width);
                check_field("image_height", report_want.image_height,
                            result_ch.data.image_height);
                check_field("max_sample", report_want.max_sample, result_ch.data.max_sample);
                check_field("channel_count", report_want.channel_count,
                            result_ch.data.channel_count);
                check_field("error_code", report_want.error_code, result_ch.data.error_code);
                check_field("last", report_want.last, result_ch.data.last);
            end
            report_count++;
        end
    end

    // receiver: ready drops at random per the current idle rate
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // byte driving
    // ---------------------------------------------------------------

    // one byte transaction; valid only drops when a gap is drawn
    task automatic send_byte(input logic [7:0] value, input logic new_file);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data  <= {value, new_file};
        @(posedge clk);
        while (byte_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        if (!parse_and_scale(value, new_file))
        begin
            parsed_bytes++;
        end
    endtask

    task automatic send_text(input string s, input logic new_file);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], new_file && (i == 0));
        end
    endtask

    task automatic send_decimal(input int unsigned v, input int zeros);
        repeat (zeros)
        begin
            send_byte(CH_ZERO, 1'b0);
        end
        send_text($sformatf("%0d", v), 1'b0);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NEWLINE;
            default: return CH_RETURN;
        endcase
    endfunction

    // comment text: plenty of digits that must be skipped, never a newline
    function automatic logic [7:0] comment_byte();
        logic [7:0] c;
        if ($urandom_range(99) < 30)
        begin
            return CH_ZERO + 8'($urandom_range(9));
        end
        c = 8'($urandom_range(255, 1));
        if (c == CH_NEWLINE)
        begin
            c = CH_HASH;
        end
        return c;
    endfunction

    // whitespace and comments between header fields
    task automatic send_separator(input bit at_least_one);
        int extra;
        if (at_least_one)
        begin
            send_byte(pick_space(), 1'b0);
        end
        extra = ($urandom_range(99) < 60) ? 0 : $urandom_range(2, 1);
        repeat (extra)
        begin
            if ($urandom_range(99) < 45)
            begin
                send_byte(CH_HASH, 1'b0);
                repeat ($urandom_range(6))
                begin
                    send_byte(comment_byte(), 1'b0);
                end
                send_byte(CH_NEWLINE, 1'b0);
            end
            else
            begin
                send_byte(pick_space(), 1'b0);
            end
        end
    endtask

    // small images mostly, now and then zero or a large value, mostly one that saturates
    function automatic int unsigned pick_dimension();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6)
        begin
            return 0;
        end
        if (r < 9)
        begin
            return $urandom_range(99999999, 65530);
        end
        return $urandom_range(5, 1);
    endfunction

    function automatic int unsigned pick_maxval();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            return 0;
        end
        if (r < 16)
        begin
            return $urandom_range(999999, 256);
        end
        if (r < 28)
        begin
            return MAX_LEVEL;
        end
        if (r < 34)
        begin
            return 1;
        end
        return $urandom_range(254, 1);
    endfunction

    // raster bytes: extremes, values around maxval, then anything
    function automatic logic [7:0] pick_level();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return 8'h00;
        end
        if (r < 20)
        begin
            return 8'hFF;
        end
        if (r < 35)
        begin
            return 8'(maxval_q) + 8'($urandom_range(1));
        end
        return 8'($urandom_range(255));
    endfunction

    // one random file, mostly well formed, some with bad magic or noise
    task automatic send_random_file();
        int unsigned style;
        int unsigned r;
        int unsigned cap;
        int unsigned sent;
        logic [7:0]  magic_digit;
        style = $urandom_range(99);
        send_byte(($urandom_range(99) < 95) ? CH_P : 8'($urandom_range(255)), 1'b1);
        r = $urandom_range(99);
        if (r < 84)
        begin
            magic_digit = $urandom_range(1) ? CH_SIX : CH_FIVE;
        end
        else if (r < 93)
        begin
            magic_digit = CH_ONE + 8'($urandom_range(3));
        end
        else
        begin
            magic_digit = 8'($urandom_range(255));
        end
        send_byte(magic_digit, 1'b0);
        if (style < 8 && scan_phase != SCAN_DONE)
        begin
            // broken header: raw noise until the next file
            repeat ($urandom_range(30, 4))
            begin
                send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
        else if (scan_phase != SCAN_DONE)
        begin
            send_separator(1'b0);
            for (int field = 0; field < 3; field++)
            begin
                if ($urandom_range(99) < 4)
                begin
                    // nul while skipping ends the number as zero
                    send_byte(CH_NUL, 1'b0);
                    if (field != 2)
                    begin
                        send_separator(1'b0);
                    end
                end
                else
                begin
                    send_decimal((field == 2) ? pick_maxval() : pick_dimension(),
                                 ($urandom_range(99) < 10) ? $urandom_range(2, 1) : 0);
                    if (field == 2)
                    begin
                        send_byte(pick_space(), 1'b0);
                    end
                    else
                    begin
                        send_separator(1'b1);
                    end
                end
            end
            // full raster mostly, sometimes cut short by the next file
            cap  = ($urandom_range(99) < 10) ? $urandom_range(8) : 120;
            sent = 0;
            while (scan_phase == SCAN_RASTER && sent < cap)
            begin
                send_byte(pick_level(), 1'b0);
                sent++;
            end
        end
        // trailing bytes; the block ignores them once the file has ended
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(3, 1))
            begin
                send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // bad letter (second byte still taken), bad digit, unsupported format
    task automatic test_magic_errors();
        send_byte(CH_LETTER_X, 1'b0);
        send_byte(CH_P, 1'b0);
        send_text("P0", 1'b1);
        send_text("P4", 1'b1);
    endtask

    // comment with a digit in it, samples 0 and 255, the second saturates
    task automatic test_commented_graymap();
        send_text("P5#9\n2 1 7 ", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // nul for width and height gives an empty pixmap, header carries last
    task automatic test_empty_pixmap();
        send_text("P6", 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_text("9 ", 1'b0);
    endtask

    task automatic test_maxval_zero();
        send_text("P5", 1'b1);
        repeat (3)
        begin
            send_byte(CH_NUL, 1'b0);
        end
    endtask

    task automatic test_random_files(input int send_pct, input int recv_pct, input int quota);
        int goal;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        goal              = parsed_bytes + quota;
        while (parsed_bytes < goal)
        begin
            send_random_file();
        end
    endtask

    // main sequence
    initial
    begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data      = '0;
        failures          = 0;
        parsed_bytes      = 0;
        report_count      = 0;
        sender_idle_pct   = 28;
        receiver_idle_pct = 63;
        restart_parse();
        repeat (7)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        test_magic_errors();
        test_commented_graymap();
        test_empty_pixmap();
        test_maxval_zero();

        // sender-light, receiver-heavy stalls, then swapped, then back to back
        test_random_files(28, 63, 560);
        test_random_files(63, 28, 560);
        test_random_files(0, 0, 580);

        @(negedge clk);
        byte_ch.valid <= 1'b0;

        // drain, then leave room for a late stray report
        while (pnm_reports_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40)
        begin
            @(posedge clk);
        end
        if (failures == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #(4_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
